// File: hdl/sbh_pkg.sv
// Shared types, constants and round-constant table for the SHA-256 byte hasher.
// No dependencies.
package sbh_pkg;

  localparam int BLOCK_BITS = 512;
  localparam int LEN_BITS   = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    logic      count_len;
    byte_sel_t byte_sel;
    logic      start_comp;
    logic      round_en;
    logic      fold;
    logic      emit_next;
    logic      clear;
  } sbh_cmd_t;

  typedef struct packed {
    logic [5:0] count;
    logic       last_round;
    logic       last_emit;
  } sbh_stat_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: hdl/sbh_datapath.sv
// Datapath: 512-bit block/schedule shift register, bit length, chaining words,
// round registers and digest word select. Depends on sbh_pkg.
module sbh_datapath import sbh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sbh_cmd_t   cmd,
  input  logic [7:0] data_byte,
  output sbh_stat_t  stat,
  output word_t      digest_word,
  output logic [2:0] word_index
);

  logic [BLOCK_BITS-1:0] blk;
  logic [5:0]            count;
  logic [LEN_BITS-1:0]   bitlen;
  word_t                 h [8];
  word_t                 v [8];
  logic [5:0]            round;
  logic [2:0]            idx;

  logic [7:0] in_byte;
  logic [7:0] len_byte;
  word_t      w0, w1, w9, w14, w_new;
  word_t      s0, s1, big0, big1, ch, maj, t1, t2;

  assign len_byte = bitlen[{~count[2:0], 3'b000} +: 8];

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: in_byte = data_byte;
      SEL_MARK: in_byte = PAD_MARK;
      SEL_LEN:  in_byte = len_byte;
      default:  in_byte = 8'h00;
    endcase
  end

  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign big1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + round_k(round) + w0;
  assign big0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[BLOCK_BITS-9:0], in_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[BLOCK_BITS-33:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count  <= '0;
      bitlen <= '0;
      idx    <= '0;
      round  <= '0;
      for (int i = 0; i < 8; i++) h[i] <= IV[i];
    end else begin
      if (cmd.shift_en) count <= count + 6'd1;
      if (cmd.count_len) bitlen <= bitlen + 64'd8;
      if (cmd.start_comp) round <= '0;
      else if (cmd.round_en) round <= round + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
      if (cmd.emit_next) idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.round_en) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign stat.count      = count;
  assign stat.last_round = (round == 6'd63);
  assign stat.last_emit  = (idx == 3'd7);
  assign digest_word     = h[idx];
  assign word_index      = idx;

endmodule

// File: hdl/sbh_ctrl.sv
// Controller: sequences byte loading, padding, compression and digest output.
// Depends on sbh_pkg.
module sbh_ctrl import sbh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      req_type,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sbh_stat_t stat,
  output sbh_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   padding, padding_next;
  logic   first, first_next;
  logic   len_ok, len_ok_next;
  logic   in_beat, out_beat, full;

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_EMIT);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign full      = (stat.count == 6'd63);

  always_comb begin
    state_next   = state;
    padding_next = padding;
    first_next   = first;
    len_ok_next  = len_ok;
    cmd          = '0;
    cmd.byte_sel = SEL_DATA;
    case (state)
      ST_LOAD: begin
        if (in_beat) begin
          if (req_type) begin
            state_next   = ST_PAD;
            padding_next = 1'b1;
            first_next   = 1'b1;
            len_ok_next  = (stat.count < LEN_POS);
          end else begin
            cmd.shift_en  = 1'b1;
            cmd.count_len = 1'b1;
            if (full) begin
              cmd.start_comp = 1'b1;
              state_next     = ST_COMP;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        first_next   = 1'b0;
        if (first) cmd.byte_sel = SEL_MARK;
        else if (len_ok && stat.count >= LEN_POS) cmd.byte_sel = SEL_LEN;
        else cmd.byte_sel = SEL_ZERO;
        if (full) begin
          cmd.start_comp = 1'b1;
          state_next     = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        if (stat.last_round) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!padding) state_next = ST_LOAD;
        else if (len_ok) state_next = ST_EMIT;
        else begin
          len_ok_next = 1'b1;
          state_next  = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          if (stat.last_emit) begin
            cmd.clear    = 1'b1;
            padding_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      padding <= 1'b0;
      first   <= 1'b0;
      len_ok  <= 1'b0;
    end else begin
      state   <= state_next;
      padding <= padding_next;
      first   <= first_next;
      len_ok  <= len_ok_next;
    end
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_beat && stat.last_emit |=> in_ready && stat.count == 6'd0)
    else $error("not back to load after last digest word");
  a_comp: assert property (@(posedge clk) disable iff (rst)
    cmd.start_comp |=> state == ST_COMP)
    else $error("compression did not start");
`endif

endmodule

// File: hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 over a byte stream. One append beat per cycle is taken while the
// block is loading; the 64th byte of a block starts a compression that runs
// one round per cycle, so loading stalls for the compression (64 rounds and one
// chaining-word update). A finish beat pads one byte per cycle up to the end
// of the block (one or two blocks, each followed by its compression)
// and then offers the eight digest words, H0 first, one per accepted beat.
// After the last word the hasher is back in its initial state.
module sha256_byte_stream_hasher_unit import sbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sbh_cmd_t  cmd;
  sbh_stat_t stat;

  sbh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbh_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign last_word = stat.last_emit;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for sha256_byte_stream_hasher_unit: drives append and finish
// beats, predicts each digest in a scoreboard class and checks every output beat.
// Depends on sbh_pkg and the hasher RTL.
`timescale 1ns / 100ps

typedef struct {
  logic [31:0] word;
  logic [2:0]  idx;
  logic        last;
} digest_beat_t;

class digest_scoreboard;
  logic [7:0]  msg_blk [64];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [31:0] chain [8];
  digest_beat_t pending [$];
  int errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    fill = '0;
    bit_len = '0;
    for (int i = 0; i < 8; i++) chain[i] = sbh_pkg::IV[i];
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sbh_pkg::round_k(i[5:0]) + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void note_beat(logic finish, logic [7:0] b);
    logic [63:0] total;
    digest_beat_t d;
    if (!finish) begin
      msg_blk[fill] = b;
      if (fill == 6'd63) begin
        compress();
        bit_len += 512;
      end
      fill++;
      return;
    end
    total = bit_len + 64'(fill) * 8;
    msg_blk[fill] = 8'h80;
    for (int i = int'(fill) + 1; i < 64; i++) msg_blk[i] = '0;
    if (fill >= 6'd56) begin
      compress();
      for (int i = 0; i < 56; i++) msg_blk[i] = '0;
    end
    for (int i = 0; i < 8; i++) msg_blk[56+i] = total[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i]; d.idx = i[2:0]; d.last = (i == 7);
      pending.push_back(d);
    end
    restart();
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
    digest_beat_t e;
    if (pending.size() == 0) begin
      $error("unexpected digest beat %h", word);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (word !== e.word) begin
      $error("digest_word exp %h got %h", e.word, word); errors++;
    end
    if (idx !== e.idx) begin
      $error("word_index exp %0d got %0d", e.idx, idx); errors++;
    end
    if (last !== e.last) begin
      $error("last_word exp %0d got %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 0, rst = 1;
  logic in_valid = 0, req_type = 0, out_ready = 0;
  logic [7:0] data_byte = '0;
  logic in_ready, out_valid, last_word;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  digest_scoreboard sb = new();
  bit calm = 0;
  int hold_cycles = 0;

  sha256_byte_stream_hasher_unit i_dut (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_beat(logic fin, logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1; req_type <= fin; data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(fin, b);
  endtask

  task automatic send_msg(int len, int kind);
    for (int i = 0; i < len; i++)
      send_beat(1'b0, kind == 0 ? 8'h00 : kind == 1 ? 8'hff : 8'($urandom));
    send_beat(1'b1, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(digest_word, word_index, last_word);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else if (calm) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_beat(1'b1, 8'h00);
    send_msg(3, 2);
    send_msg(55, 1);
    send_msg(56, 0);
    send_msg(63, 2);
    send_msg(64, 1);
    send_msg(0, 2);
    hold_cycles <= 400;
    for (int m = 0; m < 6; m++) send_msg(0, 2);
    n = 254;
    while (n < 420) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
      if (n > 330) calm = 1;
      send_msg(len, 2);
      n += len + 1;
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
